>>> design/dcr_pkg.sv
package dcr_pkg;

   // default sizes
   localparam int TABLE_ENTRIES_DEFAULT = 256;
   localparam int DEPTH_BITS_DEFAULT    = 32;
   localparam int BASE_ENTRIES          = 256;
   localparam int FRAC_BITS             = 8;

   // codes
   localparam logic       ACTION_MEASURE = 1'b0;
   localparam logic       ACTION_RENDER  = 1'b1;
   localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;

   // request word
   typedef struct packed {
      logic               action;
      logic               frame_start;
      logic signed [31:0] depth_value;
      logic               depth_valid;
   } req_word_type;

   // response word
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rsp_word_type;

   // reversed viridis, red channel
   localparam logic [7:0] RED_TABLE [BASE_ENTRIES] = '{
      8'hfd, 8'hfb, 8'hf8, 8'hf6, 8'hf4, 8'hf1, 8'hef, 8'hec, 8'hea, 8'he7, 8'he5, 8'he2,
      8'hdf, 8'hdd, 8'hda, 8'hd8, 8'hd5, 8'hd2, 8'hd0, 8'hcd, 8'hca, 8'hc8, 8'hc5, 8'hc2,
      8'hc0, 8'hbd, 8'hba, 8'hb8, 8'hb5, 8'hb2, 8'hb0, 8'had, 8'haa, 8'ha8, 8'ha5, 8'ha2,
      8'ha0, 8'h9d, 8'h9b, 8'h98, 8'h95, 8'h93, 8'h90, 8'h8e, 8'h8b, 8'h89, 8'h86, 8'h84,
      8'h81, 8'h7f, 8'h7c, 8'h7a, 8'h77, 8'h75, 8'h73, 8'h70, 8'h6e, 8'h6c, 8'h69, 8'h67,
      8'h65, 8'h63, 8'h60, 8'h5e, 8'h5c, 8'h5a, 8'h58, 8'h56, 8'h54, 8'h52, 8'h50, 8'h4e,
      8'h4c, 8'h4a, 8'h48, 8'h46, 8'h44, 8'h42, 8'h40, 8'h3f, 8'h3d, 8'h3b, 8'h3a, 8'h38,
      8'h37, 8'h35, 8'h34, 8'h32, 8'h31, 8'h2f, 8'h2e, 8'h2d, 8'h2c, 8'h2a, 8'h29, 8'h28,
      8'h27, 8'h26, 8'h25, 8'h25, 8'h24, 8'h23, 8'h22, 8'h22, 8'h21, 8'h21, 8'h20, 8'h20,
      8'h1f, 8'h1f, 8'h1f, 8'h1f, 8'h1f, 8'h1f, 8'h1e, 8'h1e, 8'h1e, 8'h1f, 8'h1f, 8'h1f,
      8'h1f, 8'h1f, 8'h1f, 8'h1f, 8'h20, 8'h20, 8'h20, 8'h21, 8'h21, 8'h21, 8'h21, 8'h22,
      8'h22, 8'h22, 8'h23, 8'h23, 8'h23, 8'h24, 8'h24, 8'h25, 8'h25, 8'h25, 8'h26, 8'h26,
      8'h26, 8'h27, 8'h27, 8'h27, 8'h28, 8'h28, 8'h29, 8'h29, 8'h29, 8'h2a, 8'h2a, 8'h2a,
      8'h2b, 8'h2b, 8'h2c, 8'h2c, 8'h2c, 8'h2d, 8'h2d, 8'h2e, 8'h2e, 8'h2e, 8'h2f, 8'h2f,
      8'h30, 8'h30, 8'h31, 8'h31, 8'h31, 8'h32, 8'h32, 8'h33, 8'h33, 8'h34, 8'h34, 8'h35,
      8'h35, 8'h36, 8'h36, 8'h37, 8'h37, 8'h38, 8'h38, 8'h39, 8'h39, 8'h3a, 8'h3a, 8'h3b,
      8'h3b, 8'h3c, 8'h3c, 8'h3d, 8'h3d, 8'h3e, 8'h3e, 8'h3e, 8'h3f, 8'h3f, 8'h40, 8'h40,
      8'h41, 8'h41, 8'h42, 8'h42, 8'h42, 8'h43, 8'h43, 8'h44, 8'h44, 8'h44, 8'h45, 8'h45,
      8'h45, 8'h46, 8'h46, 8'h46, 8'h46, 8'h47, 8'h47, 8'h47, 8'h47, 8'h47, 8'h48, 8'h48,
      8'h48, 8'h48, 8'h48, 8'h48, 8'h48, 8'h48, 8'h48, 8'h48, 8'h48, 8'h48, 8'h48, 8'h48,
      8'h48, 8'h48, 8'h48, 8'h47, 8'h47, 8'h47, 8'h47, 8'h47, 8'h46, 8'h46, 8'h46, 8'h46,
      8'h45, 8'h45, 8'h44, 8'h44
   };

   // reversed viridis, green channel
   localparam logic [7:0] GREEN_TABLE [BASE_ENTRIES] = '{
      8'he7, 8'he7, 8'he6, 8'he6, 8'he6, 8'he5, 8'he5, 8'he5, 8'he5, 8'he4, 8'he4, 8'he4,
      8'he3, 8'he3, 8'he3, 8'he2, 8'he2, 8'he2, 8'he1, 8'he1, 8'he1, 8'he0, 8'he0, 8'hdf,
      8'hdf, 8'hdf, 8'hde, 8'hde, 8'hde, 8'hdd, 8'hdd, 8'hdc, 8'hdc, 8'hdb, 8'hdb, 8'hda,
      8'hda, 8'hd9, 8'hd9, 8'hd8, 8'hd8, 8'hd7, 8'hd7, 8'hd6, 8'hd6, 8'hd5, 8'hd5, 8'hd4,
      8'hd3, 8'hd3, 8'hd2, 8'hd1, 8'hd1, 8'hd0, 8'hd0, 8'hcf, 8'hce, 8'hcd, 8'hcd, 8'hcc,
      8'hcb, 8'hcb, 8'hca, 8'hc9, 8'hc8, 8'hc8, 8'hc7, 8'hc6, 8'hc5, 8'hc5, 8'hc4, 8'hc3,
      8'hc2, 8'hc1, 8'hc1, 8'hc0, 8'hbf, 8'hbe, 8'hbd, 8'hbc, 8'hbc, 8'hbb, 8'hba, 8'hb9,
      8'hb8, 8'hb7, 8'hb6, 8'hb6, 8'hb5, 8'hb4, 8'hb3, 8'hb2, 8'hb1, 8'hb0, 8'haf, 8'hae,
      8'had, 8'had, 8'hac, 8'hab, 8'haa, 8'ha9, 8'ha8, 8'ha7, 8'ha6, 8'ha5, 8'ha4, 8'ha3,
      8'ha2, 8'ha1, 8'ha1, 8'ha0, 8'h9f, 8'h9e, 8'h9d, 8'h9c, 8'h9b, 8'h9a, 8'h99, 8'h98,
      8'h97, 8'h96, 8'h95, 8'h94, 8'h93, 8'h92, 8'h92, 8'h91, 8'h90, 8'h8f, 8'h8e, 8'h8d,
      8'h8c, 8'h8b, 8'h8a, 8'h89, 8'h88, 8'h87, 8'h86, 8'h85, 8'h84, 8'h83, 8'h82, 8'h82,
      8'h81, 8'h80, 8'h7f, 8'h7e, 8'h7d, 8'h7c, 8'h7b, 8'h7a, 8'h79, 8'h78, 8'h77, 8'h76,
      8'h75, 8'h74, 8'h73, 8'h72, 8'h71, 8'h71, 8'h70, 8'h6f, 8'h6e, 8'h6d, 8'h6c, 8'h6b,
      8'h6a, 8'h69, 8'h68, 8'h67, 8'h66, 8'h65, 8'h64, 8'h63, 8'h62, 8'h61, 8'h60, 8'h5f,
      8'h5e, 8'h5d, 8'h5c, 8'h5b, 8'h5a, 8'h59, 8'h58, 8'h56, 8'h55, 8'h54, 8'h53, 8'h52,
      8'h51, 8'h50, 8'h4f, 8'h4e, 8'h4d, 8'h4c, 8'h4a, 8'h49, 8'h48, 8'h47, 8'h46, 8'h45,
      8'h44, 8'h42, 8'h41, 8'h40, 8'h3f, 8'h3e, 8'h3d, 8'h3b, 8'h3a, 8'h39, 8'h38, 8'h37,
      8'h35, 8'h34, 8'h33, 8'h32, 8'h30, 8'h2f, 8'h2e, 8'h2d, 8'h2c, 8'h2a, 8'h29, 8'h28,
      8'h26, 8'h25, 8'h24, 8'h23, 8'h21, 8'h20, 8'h1f, 8'h1d, 8'h1c, 8'h1b, 8'h1a, 8'h18,
      8'h17, 8'h16, 8'h14, 8'h13, 8'h11, 8'h10, 8'h0e, 8'h0d, 8'h0b, 8'h0a, 8'h08, 8'h07,
      8'h05, 8'h04, 8'h02, 8'h01
   };

   // reversed viridis, blue channel
   localparam logic [7:0] BLUE_TABLE [BASE_ENTRIES] = '{
      8'h25, 8'h23, 8'h21, 8'h20, 8'h1e, 8'h1d, 8'h1c, 8'h1b, 8'h1a, 8'h19, 8'h19, 8'h18,
      8'h18, 8'h18, 8'h19, 8'h19, 8'h1a, 8'h1b, 8'h1c, 8'h1d, 8'h1f, 8'h20, 8'h21, 8'h23,
      8'h25, 8'h26, 8'h28, 8'h29, 8'h2b, 8'h2d, 8'h2f, 8'h30, 8'h32, 8'h34, 8'h36, 8'h37,
      8'h39, 8'h3b, 8'h3c, 8'h3e, 8'h40, 8'h41, 8'h43, 8'h45, 8'h46, 8'h48, 8'h49, 8'h4b,
      8'h4d, 8'h4e, 8'h50, 8'h51, 8'h53, 8'h54, 8'h56, 8'h57, 8'h58, 8'h5a, 8'h5b, 8'h5c,
      8'h5e, 8'h5f, 8'h60, 8'h62, 8'h63, 8'h64, 8'h65, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h6b,
      8'h6c, 8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
      8'h78, 8'h79, 8'h79, 8'h7a, 8'h7b, 8'h7c, 8'h7c, 8'h7d, 8'h7e, 8'h7f, 8'h7f, 8'h80,
      8'h81, 8'h81, 8'h82, 8'h82, 8'h83, 8'h83, 8'h84, 8'h85, 8'h85, 8'h85, 8'h86, 8'h86,
      8'h87, 8'h87, 8'h88, 8'h88, 8'h88, 8'h89, 8'h89, 8'h89, 8'h8a, 8'h8a, 8'h8a, 8'h8b,
      8'h8b, 8'h8b, 8'h8b, 8'h8c, 8'h8c, 8'h8c, 8'h8c, 8'h8c, 8'h8d, 8'h8d, 8'h8d, 8'h8d,
      8'h8d, 8'h8d, 8'h8d, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e,
      8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e,
      8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e,
      8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8e, 8'h8d, 8'h8d, 8'h8d, 8'h8d, 8'h8d,
      8'h8d,
      8'h8d, 8'h8d, 8'h8d, 8'h8c, 8'h8c, 8'h8c, 8'h8c, 8'h8c, 8'h8c, 8'h8b, 8'h8b, 8'h8b,
      8'h8b, 8'h8a, 8'h8a, 8'h8a, 8'h8a, 8'h89, 8'h89, 8'h89, 8'h88, 8'h88, 8'h88, 8'h87,
      8'h87, 8'h86, 8'h86, 8'h85, 8'h85, 8'h84, 8'h84, 8'h83, 8'h83, 8'h82, 8'h81, 8'h81,
      8'h80, 8'h7f, 8'h7e, 8'h7e, 8'h7d, 8'h7c, 8'h7b, 8'h7a, 8'h7a, 8'h79, 8'h78, 8'h77,
      8'h76, 8'h75, 8'h74, 8'h73, 8'h71, 8'h70, 8'h6f, 8'h6e, 8'h6d, 8'h6c, 8'h6a, 8'h69,
      8'h68, 8'h67, 8'h65, 8'h64, 8'h63, 8'h61, 8'h60, 8'h5e, 8'h5d, 8'h5c, 8'h5a, 8'h59,
      8'h57, 8'h56, 8'h54
   };

endpackage

>>> design/depth_to_colormap_render_top.sv
// measure word: accepted, range updated in the cycle after; next word taken from S_IDLE
// render word outside the range or blank: S_CHECK, S_FETCH, S_BLEND, result loaded when free
// render word inside the range: S_CHECK, S_MULT, S_DIVIDE, S_FETCH, S_BLEND to the result;
// S_DIVIDE runs the restoring divider, one quotient bit per cycle
// the output register lets the next word in while a result waits to be taken
// reset: synchronous, clears range, range-seen flag, sequencer and output valid
module depth_to_colormap_render_top #(
   parameter int TABLE_ENTRIES = dcr_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int DEPTH_BITS    = dcr_pkg::DEPTH_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dcr_pkg::req_word_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dcr_pkg::rsp_word_type rsp_word
);
   import dcr_pkg::*;

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int QW = IW + FRAC_BITS;
   localparam int PW = DEPTH_BITS + IW;
   localparam int CW = $clog2(QW);
   localparam logic [IW-1:0]         LAST_IDX = IW'(TABLE_ENTRIES - 1);
   localparam logic [DEPTH_BITS-1:0] SIGN_BIT = {1'b1, {(DEPTH_BITS - 1){1'b0}}};
   localparam logic [7:0]            BASE_LAST = 8'(BASE_ENTRIES - 1);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CHECK  = 6'b000010,
      S_MULT   = 6'b000100,
      S_DIVIDE = 6'b001000,
      S_FETCH  = 6'b010000,
      S_BLEND  = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   req_word_type            item_ff, item_in;
   logic [DEPTH_BITS-1:0]   lo_ff, lo_in;
   logic [DEPTH_BITS-1:0]   hi_ff, hi_in;
   logic                    seen_ff, seen_in;
   logic [DEPTH_BITS-1:0]   num_ff, num_in;
   logic [DEPTH_BITS-1:0]   den_ff, den_in;
   logic [DEPTH_BITS-1:0]   rem_ff, rem_in;
   logic [QW-1:0]           quo_ff, quo_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [FRAC_BITS-1:0]    frac_ff, frac_in;
   logic                    blank_ff, blank_in;
   logic [23:0]             col_a_ff, col_b_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_word_type            rsp_word_ff, rsp_word_in;

   logic                    req_take;
   logic                    rsp_free;
   logic [DEPTH_BITS-1:0]   depth_b;
   logic [PW-1:0]           prod;
   logic [DEPTH_BITS:0]     rem_ext;
   logic [DEPTH_BITS:0]     den_ext;
   logic [DEPTH_BITS:0]     rem_diff;
   logic                    take_bit;
   logic                    seen_v;
   logic [DEPTH_BITS-1:0]   lo_v;
   logic [DEPTH_BITS-1:0]   hi_v;
   rsp_word_type            blend_word;

   // table index clamped to the fixed entries
   function automatic logic [7:0] rom_addr(input logic [IW-1:0] idx);
      logic [15:0] wide;
      wide = 16'(idx);
      return (wide > 16'(BASE_LAST)) ? BASE_LAST : wide[7:0];
   endfunction

   function automatic logic [23:0] color_at(input logic [7:0] addr);
      return {RED_TABLE[addr], GREEN_TABLE[addr], BLUE_TABLE[addr]};
   endfunction

   // one channel, linear blend rounded half up
   function automatic logic [7:0] blend_chan(input logic [7:0] ca, input logic [7:0] cb,
                                             input logic [FRAC_BITS-1:0] f);
      logic [16:0] acc;
      acc = ({9'd0, ca} * (17'd256 - {9'd0, f})) + ({9'd0, cb} * {9'd0, f}) + 17'd128;
      return acc[15:8];
   endfunction

   // handshake
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // offset-binary depth so unsigned compares follow signed order
   assign depth_b = DEPTH_BITS'(item_ff.depth_value) ^ SIGN_BIT;

   // scaled numerator
   assign prod = PW'(num_ff) * PW'(LAST_IDX);

   // one restoring divide step
   assign rem_ext  = {rem_ff, quo_ff[QW-1]};
   assign den_ext  = {1'b0, den_ff};
   assign rem_diff = rem_ext - den_ext;
   assign take_bit = (rem_ext >= den_ext);

   // measure fold, after an optional clear
   assign seen_v = item_ff.frame_start ? 1'b0 : seen_ff;
   assign lo_v   = item_ff.frame_start ? SIGN_BIT : lo_ff;
   assign hi_v   = item_ff.frame_start ? SIGN_BIT : hi_ff;

   // color blend from the two fetched entries
   assign blend_word.red   = blend_chan(col_a_ff[23:16], col_b_ff[23:16], frac_ff);
   assign blend_word.green = blend_chan(col_a_ff[15:8], col_b_ff[15:8], frac_ff);
   assign blend_word.blue  = blend_chan(col_a_ff[7:0], col_b_ff[7:0], frac_ff);
   assign blend_word.alpha = ALPHA_OPAQUE;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      seen_in      = seen_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      blank_in     = blank_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               item_in  = req_word;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (item_ff.action == ACTION_MEASURE) begin
               seen_in = seen_v;
               lo_in   = lo_v;
               hi_in   = hi_v;
               if (item_ff.depth_valid) begin
                  seen_in = 1'b1;
                  if (!seen_v) begin
                     lo_in = depth_b;
                     hi_in = depth_b;
                  end else begin
                     if (depth_b < lo_v) lo_in = depth_b;
                     if (depth_b > hi_v) hi_in = depth_b;
                  end
               end
               state_in = S_IDLE;
            end else begin
               blank_in = 1'b0;
               frac_in  = '0;
               idx_in   = '0;
               state_in = S_FETCH;
               if (!item_ff.depth_valid || !seen_ff || (hi_ff <= lo_ff)) begin
                  blank_in = 1'b1;
               end else if (depth_b <= lo_ff) begin
                  idx_in = '0;
               end else if (depth_b >= hi_ff) begin
                  idx_in = LAST_IDX;
               end else begin
                  num_in   = depth_b - lo_ff;
                  den_in   = hi_ff - lo_ff;
                  state_in = S_MULT;
               end
            end
         end
         S_MULT: begin
            rem_in   = prod[PW-1:IW];
            quo_in   = {prod[IW-1:0], {FRAC_BITS{1'b0}}};
            count_in = '0;
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            rem_in   = take_bit ? rem_diff[DEPTH_BITS-1:0] : rem_ext[DEPTH_BITS-1:0];
            quo_in   = {quo_ff[QW-2:0], take_bit};
            count_in = count_ff + CW'(1);
            if (count_ff == CW'(QW - 1)) begin
               idx_in   = quo_in[QW-1:FRAC_BITS];
               frac_in  = quo_in[FRAC_BITS-1:0];
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_BLEND;
         end
         S_BLEND: begin
            if (rsp_free) begin
               rsp_word_in  = blank_ff ? '0 : blend_word;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and range state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seen_ff      <= 1'b0;
         lo_ff        <= SIGN_BIT;
         hi_ff        <= SIGN_BIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      count_ff    <= count_in;
      idx_ff      <= idx_in;
      frac_ff     <= frac_in;
      blank_ff    <= blank_in;
      rsp_word_ff <= rsp_word_in;
   end

   // color table, registered read of both neighbors
   always_ff @(posedge clock) begin
      if (state_ff == S_FETCH) begin
         col_a_ff <= color_at(rom_addr(idx_ff));
         col_b_ff <= color_at(rom_addr(idx_ff + IW'(1)));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // tracked range stays ordered once a sample is in
   assert property (@(posedge clock) disable iff (reset) seen_ff |-> (lo_ff <= hi_ff))
      else $error("range low above range high");

   // divider remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset) (state_ff == S_DIVIDE) |->
                    (rem_ff < den_ff))
      else $error("divider remainder out of range");

   // a shown word is either opaque or fully transparent black
   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |->
                    (rsp_word_ff.alpha == ALPHA_OPAQUE) || (rsp_word_ff == '0))
      else $error("bad alpha on response word");

   // a measure word never produces a response
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == S_CHECK && item_ff.action == ACTION_MEASURE) |=>
                    !$rose(rsp_valid_ff))
      else $error("response from a measure word");

endmodule

>>> test/tb_depth_to_colormap_render_top.sv
module tb_depth_to_colormap_render_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dcr_pkg::*;

   localparam int TABLE_LAST   = TABLE_ENTRIES_DEFAULT - 1;
   localparam int RANDOM_WORDS = 1225;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 40;

   // clock and block inputs, known from time zero
   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   int idle_pct    = 30;
   int stall_pct   = 30;
   int errors      = 0;
   int cycle_count = 0;

   // predicted range state and pixels still owed by the block
   logic signed [31:0] range_low_q  = '0;
   logic signed [31:0] range_high_q = '0;
   logic               range_seen_q = 1'b0;
   rsp_word_type       expected_pixels[$];

   depth_to_colormap_render_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial forever #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // random back-pressure on the result side
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // table entry, repeating the last fixed entry past the base table
   function automatic logic [23:0] color_entry(input int i);
      int k;
      k = (i < BASE_ENTRIES) ? i : BASE_ENTRIES - 1;
      return {RED_TABLE[k], GREEN_TABLE[k], BLUE_TABLE[k]};
   endfunction

   // linear blend of one channel, rounding half up
   function automatic logic [7:0] mix_channel(input logic [7:0] a, input logic [7:0] b,
                                              input int unsigned f);
      int unsigned sum;
      sum = a * (256 - f) + b * f + 128;
      return 8'(sum >> 8);
   endfunction

   // fold a measure word into the range, or queue the pixel a render word gives
   task automatic predict_pixel(input req_word_type w);
      rsp_word_type px;
      longint       d, lo, hi, num, den, q, qi, frac, pos;
      int           idx, f, k;
      logic [23:0]  ca, cb;
      d = longint'(w.depth_value);
      if (w.action == ACTION_MEASURE) begin
         if (w.frame_start) begin
            range_seen_q = 1'b0;
            range_low_q  = '0;
            range_high_q = '0;
         end
         if (w.depth_valid) begin
            if (!range_seen_q) begin
               range_low_q  = w.depth_value;
               range_high_q = w.depth_value;
               range_seen_q = 1'b1;
            end else begin
               if (d < longint'(range_low_q)) range_low_q = w.depth_value;
               if (d > longint'(range_high_q)) range_high_q = w.depth_value;
            end
         end
      end else begin
         px = '0;
         lo = longint'(range_low_q);
         hi = longint'(range_high_q);
         if (w.depth_valid && range_seen_q && hi > lo) begin
            if (d <= lo) begin
               {px.red, px.green, px.blue} = color_entry(0);
            end else if (d >= hi) begin
               {px.red, px.green, px.blue} = color_entry(TABLE_LAST);
            end else begin
               // exact table position with an 8-bit fraction
               num  = d - lo;
               den  = hi - lo;
               q    = num * TABLE_LAST;
               qi   = q / den;
               frac = ((q % den) << 8) / den;
               pos  = (qi << 8) + frac;
               idx  = int'(pos >> 8);
               if (idx > TABLE_LAST - 1) idx = TABLE_LAST - 1;
               f    = int'(pos & 255);
               ca   = color_entry(idx);
               cb   = color_entry(idx + 1);
               for (k = 0; k < 3; k++) begin
                  px[8 + k*8 +: 8] = mix_channel(ca[k*8 +: 8], cb[k*8 +: 8], f);
               end
            end
            px.alpha = ALPHA_OPAQUE;
         end
         expected_pixels.push_back(px);
      end
   endtask

   // compare each taken pixel with the oldest one owed
   always @(posedge clock) begin : check_pixels
      rsp_word_type want;
      string        channel_name [4];
      channel_name = '{"alpha", "blue", "green", "red"};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: pixel with none owed: got %h", $time, rsp_word);
            errors++;
         end else begin
            want = expected_pixels.pop_front();
            for (int k = 3; k >= 0; k--) begin
               if (rsp_word[k*8 +: 8] !== want[k*8 +: 8]) begin
                  $display("%0t: %s mismatch: expected %h, actual %h", $time,
                           channel_name[k], want[k*8 +: 8], rsp_word[k*8 +: 8]);
                  errors++;
               end
            end
         end
      end
   end

   function automatic req_word_type make_word(input logic act, input logic start,
                                              input logic [31:0] depth, input logic valid);
      req_word_type w;
      w.action      = act;
      w.frame_start = start;
      w.depth_value = depth;
      w.depth_valid = valid;
      return w;
   endfunction

   // present one word, with random idle cycles ahead of it, and hold it until taken
   task automatic send_word(input req_word_type w);
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      predict_pixel(w);
   endtask

   // render with no valid sample seen since reset
   task automatic test_render_before_measure();
      send_word(make_word(ACTION_RENDER, 1'b0, 32'h0000_0000, 1'b1));
   endtask

   // full signed range: both ends, the clamp near the top, missing and frame-start renders
   task automatic test_full_range();
      send_word(make_word(ACTION_MEASURE, 1'b1, 32'h8000_0000, 1'b1));
      send_word(make_word(ACTION_MEASURE, 1'b0, 32'h7FFF_FFFF, 1'b1));
      send_word(make_word(ACTION_RENDER, 1'b0, 32'h8000_0000, 1'b1));
      send_word(make_word(ACTION_RENDER, 1'b0, 32'h7FFF_FFFF, 1'b1));
      send_word(make_word(ACTION_RENDER, 1'b0, 32'h0000_0000, 1'b1));
      send_word(make_word(ACTION_RENDER, 1'b0, 32'h8000_0001, 1'b1));
      send_word(make_word(ACTION_RENDER, 1'b0, 32'h7FFF_FFFE, 1'b1));
      send_word(make_word(ACTION_RENDER, 1'b0, 32'h1234_5678, 1'b0));
      send_word(make_word(ACTION_RENDER, 1'b1, 32'h4000_0000, 1'b1));
   endtask

   // missing sample with frame start still clears the range
   task automatic test_cleared_range();
      send_word(make_word(ACTION_MEASURE, 1'b1, 32'h0001_0000, 1'b0));
      send_word(make_word(ACTION_RENDER, 1'b0, 32'h0001_0000, 1'b1));
   endtask

   // zero range, then widened; missing measure leaves range alone
   task automatic test_zero_range();
      send_word(make_word(ACTION_MEASURE, 1'b1, 32'h0005_0000, 1'b1));
      send_word(make_word(ACTION_MEASURE, 1'b0, 32'h0005_0000, 1'b1));
      send_word(make_word(ACTION_RENDER, 1'b0, 32'h0005_0000, 1'b1));
      send_word(make_word(ACTION_MEASURE, 1'b0, 32'hFFFD_0000, 1'b1));
      send_word(make_word(ACTION_MEASURE, 1'b0, 32'h7FFF_0000, 1'b0));
      send_word(make_word(ACTION_RENDER, 1'b0, 32'hFFFD_0000, 1'b1));
      send_word(make_word(ACTION_RENDER, 1'b0, 32'hFFFC_0000, 1'b1));
      send_word(make_word(ACTION_RENDER, 1'b0, 32'h0006_0000, 1'b1));
      send_word(make_word(ACTION_RENDER, 1'b0, 32'h0001_0000, 1'b1));
   endtask

   // tiny range where each step lands exactly on a table entry
   task automatic test_narrow_range();
      send_word(make_word(ACTION_MEASURE, 1'b1, 32'h0000_0000, 1'b1));
      send_word(make_word(ACTION_MEASURE, 1'b0, 32'h0000_0003, 1'b1));
      send_word(make_word(ACTION_RENDER, 1'b0, 32'h0000_0001, 1'b1));
      send_word(make_word(ACTION_RENDER, 1'b0, 32'h0000_0002, 1'b1));
   endtask

   // frames: a measure pass then a render pass, with noise words mixed in
   task automatic test_random_frames();
      int                 sent, n_meas, n_rend, mode, spread, i;
      longint             fmin, fmax, span;
      logic               fseen;
      logic signed [31:0] base, m;
      bit [63:0]          r64;
      req_word_type       w;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         // one quiet stretch with neither side idling
         if (sent >= 400 && sent < 650) begin
            idle_pct  = 0;
            stall_pct = 0;
         end else begin
            idle_pct  = 30;
            stall_pct = 30;
         end
         mode   = $urandom_range(3);
         base   = $urandom;
         spread = (mode == 1) ? $urandom_range(1, 16) :
                  (mode == 2) ? $urandom_range(256, 1 << 20) : 0;
         n_meas = $urandom_range(1, 20);
         n_rend = $urandom_range(1, 40);
         fseen  = 1'b0;
         fmin   = 0;
         fmax   = 0;
         // measure pass
         for (i = 0; i < n_meas; i++) begin
            m = (mode == 0) ? $signed($urandom) : base + $urandom_range(0, spread);
            w = make_word(ACTION_MEASURE, i == 0 || $urandom_range(99) < 2, m,
                          $urandom_range(99) >= 10);
            if ($urandom_range(99) < 8) begin
               w = make_word(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                             1'($urandom_range(1)));
            end else if (w.depth_valid) begin
               if (w.frame_start) fseen = 1'b0;
               if (!fseen || longint'(m) < fmin) fmin = longint'(m);
               if (!fseen || longint'(m) > fmax) fmax = longint'(m);
               fseen = 1'b1;
            end else if (w.frame_start) begin
               fseen = 1'b0;
            end
            send_word(w);
            sent++;
         end
         // render pass, mostly inside the measured range
         span = fmax - fmin;
         for (i = 0; i < n_rend; i++) begin
            r64 = {$urandom, $urandom};
            if (fseen && $urandom_range(99) >= 10) begin
               m = 32'(fmin + longint'(r64 % (span + 1)));
            end else begin
               m = $signed($urandom);
            end
            w = make_word(ACTION_RENDER, $urandom_range(99) < 5, m, $urandom_range(99) >= 5);
            if ($urandom_range(99) < 8) begin
               w = make_word(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                             1'($urandom_range(1)));
            end
            send_word(w);
            sent++;
         end
      end
      idle_pct  = 30;
      stall_pct = 30;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_render_before_measure();
      test_full_range();
      test_cleared_range();
      test_zero_range();
      test_narrow_range();
      test_random_frames();

      // drain: all pixels in, then room for a trailing measure word
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> sim.f
design/dcr_pkg.sv
design/depth_to_colormap_render_top.sv
test/tb_depth_to_colormap_render_top.sv
